[sv/h4rx_pkg.sv]
// Shared constants, codes and types of the H4 receive FIFO block.
`default_nettype none

package h4rx_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int FUNC_W     = 3;
    localparam int FILL_W     = 9;
    localparam int STAGE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Width that holds a fill count plus the RTS margin without wrapping
    localparam int RTS_SUM_W  = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_EVT_IND  = 8'h04;
    localparam logic [BYTE_W-1:0] RST_HW_EVT   = 8'h10;
    localparam logic [BYTE_W-1:0] RST_HW_VAL   = 8'hFE;
    localparam logic [BYTE_W-1:0] RST_MARGIN   = 8'h08;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX           = 3'd0,
        FUNC_POP          = 3'd1,
        FUNC_PEEK         = 3'd2,
        FUNC_FLUSH        = 3'd3,
        FUNC_CLR_OVF      = 3'd4,
        FUNC_STOP_SCAN    = 3'd5,
        FUNC_RESTART_SCAN = 3'd6
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EVT_IND   = 3'd0,
        CFG_HW_EVT    = 3'd1,
        CFG_HW_VAL    = 3'd2,
        CFG_MARGIN    = 3'd3,
        CFG_MAN_RTS   = 3'd4,
        CFG_SCAN_ON   = 3'd5
    } t_cfg_idx;

    typedef enum logic [STAGE_W-1:0] {
        SCAN_IDLE    = 3'd0,
        SCAN_IND     = 3'd1,
        SCAN_CODE    = 3'd2,
        SCAN_LEN     = 3'd3,
        SCAN_FOUND   = 3'd4,
        SCAN_STOPPED = 3'd5
    } t_scan;

    // Status that travels with one transaction through the result stages
    typedef struct packed {
        logic              rvalid;
        logic [FILL_W-1:0] fill;
        logic              ovf;
        logic              rts;
        t_scan             scan;
    } t_meta;

endpackage

`default_nettype wire

[sv/h4rx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module h4rx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/h4_rx_fifo_rts_error_scan.sv]
// Top level: H4 receive byte FIFO with RTS watermark and hardware-error scanner.
//
// Input channel (i_valid / o_stall): one transaction per operation, i_func
// selects receive byte, pop, peek, flush, clear overflow, stop or restart scan.
// Output channel (o_valid / i_stall): exactly one result per transaction with
// the popped or peeked byte and the status after the operation.
// Config channel (i_cfg_valid / o_cfg_ready): ready is always high; write
// only while no transaction is in flight.
// Throughput is one transaction per cycle while o_stall is low: FIFO state
// updates in the accept cycle and the single byte RAM is read once, its
// registered data is ready in the next cycle.
// Two result registers sit behind the RAM, so a new transaction is still
// taken while one result waits; o_stall rises only when both are full and
// i_stall is high. Stalled results hold their payload.
// Synchronous reset empties the FIFO, clears overflow, asserts RTS, sets the
// scanner idle and loads the register defaults. The RAM is not cleared; the
// fill count keeps unwritten entries from being read.
`default_nettype none

module h4_rx_fifo_rts_error_scan (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [h4rx_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [h4rx_pkg::BYTE_W-1:0]       i_rx_byte,
    // output channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [h4rx_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                                   o_read_valid,
    output logic      [h4rx_pkg::FILL_W-1:0]       o_fill_count,
    output logic                                   o_overflow_flag,
    output logic                                   o_rts_ready,
    output logic      [h4rx_pkg::STAGE_W-1:0]      o_scan_stage,
    // config channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [h4rx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [h4rx_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PW = h4rx_pkg::PTR_W;
    localparam int CW = h4rx_pkg::CNT_W;
    localparam int SW = h4rx_pkg::RTS_SUM_W;

    // Config registers
    logic [h4rx_pkg::BYTE_W-1:0] r_evt_ind;
    logic [h4rx_pkg::BYTE_W-1:0] r_hw_evt;
    logic [h4rx_pkg::BYTE_W-1:0] r_hw_val;
    logic [h4rx_pkg::BYTE_W-1:0] r_margin;
    logic                        r_man_rts;
    logic                        r_scan_on;

    // FIFO control state
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            r_ovf,    n_ovf;
    logic            r_rts,    n_rts;
    h4rx_pkg::t_scan r_scan,   n_scan;

    // Result stages
    logic            r_a_valid;
    h4rx_pkg::t_meta r_a_meta, n_meta;
    logic            r_o_valid;
    h4rx_pkg::t_meta r_o_meta;
    logic [h4rx_pkg::BYTE_W-1:0] r_o_byte;

    logic                        in_acc;
    logic                        a_move;
    logic                        ram_we;
    logic                        ram_re;
    logic [h4rx_pkg::BYTE_W-1:0] ram_q;

    // Advance a pointer with wrap at the FIFO depth
    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        next_ptr = (p == PW'(h4rx_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Handshake and stage movement
    assign a_move      = r_a_valid && (!r_o_valid || !i_stall);
    assign o_stall     = r_a_valid && r_o_valid && i_stall;
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Config writes; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_ind <= h4rx_pkg::RST_EVT_IND;
            r_hw_evt  <= h4rx_pkg::RST_HW_EVT;
            r_hw_val  <= h4rx_pkg::RST_HW_VAL;
            r_margin  <= h4rx_pkg::RST_MARGIN;
            r_man_rts <= 1'b1;
            r_scan_on <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (h4rx_pkg::t_cfg_idx'(i_cfg_index))
                h4rx_pkg::CFG_EVT_IND: r_evt_ind <= i_cfg_data;
                h4rx_pkg::CFG_HW_EVT:  r_hw_evt  <= i_cfg_data;
                h4rx_pkg::CFG_HW_VAL:  r_hw_val  <= i_cfg_data;
                h4rx_pkg::CFG_MARGIN:  r_margin  <= i_cfg_data;
                h4rx_pkg::CFG_MAN_RTS: r_man_rts <= i_cfg_data[0];
                h4rx_pkg::CFG_SCAN_ON: r_scan_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next FIFO, RTS and scanner state for the accepted transaction
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_rts    = r_rts;
        n_scan   = r_scan;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        n_meta.rvalid = 1'b0;
        if (in_acc) begin
            unique case (h4rx_pkg::t_func'(i_func))
                h4rx_pkg::FUNC_RX: begin
                    if (r_count < CW'(h4rx_pkg::FIFO_DEPTH)) begin
                        ram_we   = 1'b1;
                        n_wr_ptr = next_ptr(r_wr_ptr);
                        n_count  = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (r_man_rts && (SW'(n_count) + SW'(r_margin)
                                      > SW'(h4rx_pkg::FIFO_DEPTH))) begin
                        n_rts = 1'b0;
                    end
                    // step the scanner; a stopped scanner stays stopped
                    if (r_scan_on) begin
                        priority if (i_rx_byte == r_evt_ind
                                     && r_scan == h4rx_pkg::SCAN_IDLE) begin
                            n_scan = h4rx_pkg::SCAN_IND;
                        end else if (i_rx_byte == r_hw_evt
                                     && r_scan == h4rx_pkg::SCAN_IND) begin
                            n_scan = h4rx_pkg::SCAN_CODE;
                        end else if (i_rx_byte != '0
                                     && r_scan == h4rx_pkg::SCAN_CODE) begin
                            n_scan = h4rx_pkg::SCAN_LEN;
                        end else if (i_rx_byte == r_hw_val
                                     && r_scan == h4rx_pkg::SCAN_LEN) begin
                            n_scan = h4rx_pkg::SCAN_FOUND;
                        end else if (r_scan != h4rx_pkg::SCAN_STOPPED) begin
                            n_scan = (i_rx_byte == r_evt_ind) ? h4rx_pkg::SCAN_IND
                                                               : h4rx_pkg::SCAN_IDLE;
                        end else begin
                            n_scan = r_scan;
                        end
                    end
                end
                h4rx_pkg::FUNC_POP: begin
                    if (r_count != '0) begin
                        ram_re        = 1'b1;
                        n_meta.rvalid = 1'b1;
                        n_rd_ptr      = next_ptr(r_rd_ptr);
                        n_count       = r_count - 1'b1;
                        if (r_man_rts && (SW'(n_count) < SW'(r_margin))) begin
                            n_rts = 1'b1;
                        end
                    end
                end
                h4rx_pkg::FUNC_PEEK: begin
                    if (r_count != '0) begin
                        ram_re        = 1'b1;
                        n_meta.rvalid = 1'b1;
                    end
                end
                h4rx_pkg::FUNC_FLUSH: begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    n_count  = '0;
                    if (r_man_rts) begin
                        n_rts = 1'b1;
                    end
                end
                h4rx_pkg::FUNC_CLR_OVF:      n_ovf  = 1'b0;
                h4rx_pkg::FUNC_STOP_SCAN:    n_scan = h4rx_pkg::SCAN_STOPPED;
                h4rx_pkg::FUNC_RESTART_SCAN: n_scan = h4rx_pkg::SCAN_IDLE;
                default: ;
            endcase
        end
        n_meta.fill = h4rx_pkg::FILL_W'(n_count);
        n_meta.ovf  = n_ovf;
        n_meta.rts  = n_rts;
        n_meta.scan = n_scan;
    end

    // Hold FIFO control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rts    <= 1'b1;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_rts    <= n_rts;
        end
    end

    // Scanner state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= h4rx_pkg::SCAN_IDLE;
        end else begin
            r_scan <= n_scan;
        end
    end

    // Byte store
    h4rx_ram #(
        .WIDTH (h4rx_pkg::BYTE_W),
        .DEPTH (h4rx_pkg::FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    // Stage A valid: filled on accept, drained into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_meta <= n_meta;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Merge RAM data with the status of the transaction
    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_o_meta <= r_a_meta;
            r_o_byte <= r_a_meta.rvalid ? ram_q : '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_read_byte     = r_o_byte;
    assign o_read_valid    = r_o_meta.rvalid;
    assign o_fill_count    = r_o_meta.fill;
    assign o_overflow_flag = r_o_meta.ovf;
    assign o_rts_ready     = r_o_meta.rts;
    assign o_scan_stage    = r_o_meta.scan;

endmodule

`default_nettype wire

[sv/h4rx_chk.sv]
// Port-level checker for the H4 receive FIFO block, bound to the top level.
`default_nettype none

module h4rx_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_stall,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic [h4rx_pkg::BYTE_W-1:0]       o_read_byte,
    input wire logic                              o_read_valid,
    input wire logic [h4rx_pkg::FILL_W-1:0]       o_fill_count,
    input wire logic [h4rx_pkg::STAGE_W-1:0]      o_scan_stage
);

    // No result in the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_byte)
                               && $stable(o_fill_count) && $stable(o_scan_stage))
        else $error("stalled result changed");

    // A non-read result carries a zero byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_read_valid |-> o_read_byte == '0)
        else $error("byte present without a read");

    // Fill count never exceeds the depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fill_count <= h4rx_pkg::FILL_W'(h4rx_pkg::FIFO_DEPTH))
        else $error("fill count beyond depth");

    // Stall only appears with a valid result waiting on a stalled receiver
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

endmodule

bind h4_rx_fifo_rts_error_scan h4rx_chk u_h4rx_chk (.*);

`default_nettype wire

[tb/h4rx_scan_checker.sv]
// Result checker for the H4 receive FIFO: predicts each transaction and compares results.
module h4rx_scan_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel, as seen at the block
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  wire logic [h4rx_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [h4rx_pkg::BYTE_W-1:0]     i_rx_byte,
    // output channel
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  wire logic [h4rx_pkg::BYTE_W-1:0]     i_read_byte,
    input  wire logic                            i_read_valid,
    input  wire logic [h4rx_pkg::FILL_W-1:0]     i_fill_count,
    input  wire logic                            i_overflow_flag,
    input  wire logic                            i_rts_ready,
    input  wire logic [h4rx_pkg::STAGE_W-1:0]    i_scan_stage,
    // config channel
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [h4rx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [h4rx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // totals for the top
    output int                                   o_errors,
    output int                                   o_pending,
    output int                                   o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import h4rx_pkg::*;

    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic [BYTE_W-1:0] rbyte;
        logic              rvalid;
        logic [FILL_W-1:0] fill;
        logic              ovf;
        logic              rts;
        t_scan             stage;
    } t_rx_status;

    // Expected status of every transaction still in flight, oldest first
    t_rx_status status_q [$];

    // Shadow of the FIFO and its flags
    logic [BYTE_W-1:0] byte_shadow [FIFO_DEPTH];
    int unsigned       rd_idx;
    int unsigned       wr_idx;
    int unsigned       held;
    logic              ovf_seen;
    logic              rts_on;
    t_scan             scan_st;

    // Shadow of the registers
    logic [BYTE_W-1:0] reg_ind;
    logic [BYTE_W-1:0] reg_evt;
    logic [BYTE_W-1:0] reg_val;
    logic [BYTE_W-1:0] reg_margin;
    logic              reg_man_rts;
    logic              reg_scan_on;

    int err_cnt = 0;
    int res_cnt = 0;

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Advance the error-sequence scanner by one received byte
    function automatic t_scan scan_next(input t_scan cur, input logic [BYTE_W-1:0] c);
        if (c == reg_ind && cur == SCAN_IDLE)
            return SCAN_IND;
        if (c == reg_evt && cur == SCAN_IND)
            return SCAN_CODE;
        if (c != 8'h00 && cur == SCAN_CODE)
            return SCAN_LEN;
        if (c == reg_val && cur == SCAN_LEN)
            return SCAN_FOUND;
        if (cur == SCAN_STOPPED)
            return SCAN_STOPPED;
        return (c == reg_ind) ? SCAN_IND : SCAN_IDLE;
    endfunction

    // Apply one operation to the shadow state and return the status it reports
    function automatic t_rx_status apply_op(input logic [FUNC_W-1:0] f,
                                            input logic [BYTE_W-1:0] c);
        t_rx_status r;
        r.rbyte  = '0;
        r.rvalid = 1'b0;
        case (f)
            FUNC_RX: begin
                if (held < FIFO_DEPTH) begin
                    byte_shadow[wr_idx] = c;
                    wr_idx = (wr_idx + 1) % FIFO_DEPTH;
                    held++;
                end else begin
                    ovf_seen = 1'b1;
                end
                if (reg_man_rts && (held + reg_margin > FIFO_DEPTH))
                    rts_on = 1'b0;
                if (reg_scan_on)
                    scan_st = scan_next(scan_st, c);
            end
            FUNC_POP: begin
                if (held != 0) begin
                    r.rbyte  = byte_shadow[rd_idx];
                    r.rvalid = 1'b1;
                    rd_idx   = (rd_idx + 1) % FIFO_DEPTH;
                    held--;
                    if (reg_man_rts && held < reg_margin)
                        rts_on = 1'b1;
                end
            end
            FUNC_PEEK: begin
                if (held != 0) begin
                    r.rbyte  = byte_shadow[rd_idx];
                    r.rvalid = 1'b1;
                end
            end
            FUNC_FLUSH: begin
                rd_idx = 0;
                wr_idx = 0;
                held   = 0;
                if (reg_man_rts)
                    rts_on = 1'b1;
            end
            FUNC_CLR_OVF:      ovf_seen = 1'b0;
            FUNC_STOP_SCAN:    scan_st = SCAN_STOPPED;
            FUNC_RESTART_SCAN: scan_st = SCAN_IDLE;
            default: ;
        endcase
        r.fill  = FILL_W'(held);
        r.ovf   = ovf_seen;
        r.rts   = rts_on;
        r.stage = scan_st;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rx_status want;
        if (!i_rst_n) begin
            status_q.delete();
            rd_idx      = 0;
            wr_idx      = 0;
            held        = 0;
            ovf_seen    = 1'b0;
            rts_on      = 1'b1;
            scan_st     = SCAN_IDLE;
            reg_ind     = RST_EVT_IND;
            reg_evt     = RST_HW_EVT;
            reg_val     = RST_HW_VAL;
            reg_margin  = RST_MARGIN;
            reg_man_rts = 1'b1;
            reg_scan_on = 1'b1;
        end else begin
            // compare a delivered result with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                res_cnt++;
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending (fill_count %0d)",
                                              i_fill_count));
                end else begin
                    want = status_q.pop_front();
                    if (i_read_byte !== want.rbyte)
                        report_mismatch($sformatf("read_byte got %0d expected %0d",
                                                  i_read_byte, want.rbyte));
                    if (i_read_valid !== want.rvalid)
                        report_mismatch($sformatf("read_valid got %0d expected %0d",
                                                  i_read_valid, want.rvalid));
                    if (i_fill_count !== want.fill)
                        report_mismatch($sformatf("fill_count got %0d expected %0d",
                                                  i_fill_count, want.fill));
                    if (i_overflow_flag !== want.ovf)
                        report_mismatch($sformatf("overflow_flag got %0d expected %0d",
                                                  i_overflow_flag, want.ovf));
                    if (i_rts_ready !== want.rts)
                        report_mismatch($sformatf("rts_ready got %0d expected %0d",
                                                  i_rts_ready, want.rts));
                    if (i_scan_stage !== want.stage)
                        report_mismatch($sformatf("scan_stage got %0d expected %0d",
                                                  i_scan_stage, want.stage));
                end
            end
            // track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EVT_IND: reg_ind     = i_cfg_data;
                    CFG_HW_EVT:  reg_evt     = i_cfg_data;
                    CFG_HW_VAL:  reg_val     = i_cfg_data;
                    CFG_MARGIN:  reg_margin  = i_cfg_data;
                    CFG_MAN_RTS: reg_man_rts = i_cfg_data[0];
                    CFG_SCAN_ON: reg_scan_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            // predict each accepted transaction
            if (i_in_valid && !i_in_stall)
                status_q.push_back(apply_op(i_func, i_rx_byte));
        end
        o_errors  <= err_cnt;
        o_pending <= status_q.size();
        o_results <= res_cnt;
    end

endmodule

[tb/tb.sv]
// Testbench top: drives the H4 receive FIFO with directed and random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import h4rx_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASE_ITEMS   = 70;

    // Codes outside the defined sets
    localparam logic [FUNC_W-1:0]    FUNC_NOP   = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [FUNC_W-1:0]     i_func      = '0;
    logic [BYTE_W-1:0]     i_rx_byte   = '0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_stall;
    logic                  o_valid;
    logic [BYTE_W-1:0]     o_read_byte;
    logic                  o_read_valid;
    logic [FILL_W-1:0]     o_fill_count;
    logic                  o_overflow_flag;
    logic                  o_rts_ready;
    logic [STAGE_W-1:0]    o_scan_stage;
    logic                  o_cfg_ready;

    int errors;
    int pending;
    int results;

    int          send_pct = 0;
    int          recv_pct = 0;
    bit          hold_req = 1'b0;
    int          sent_total = 0;
    int          op_cnt [8];
    int unsigned cycle_cnt = 0;

    // Register values the packet generator aims at
    logic [BYTE_W-1:0] cur_ind = RST_EVT_IND;
    logic [BYTE_W-1:0] cur_evt = RST_HW_EVT;
    logic [BYTE_W-1:0] cur_val = RST_HW_VAL;

    always #CLK_HALF i_clk = ~i_clk;

    h4_rx_fifo_rts_error_scan u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_byte     (o_read_byte),
        .o_read_valid    (o_read_valid),
        .o_fill_count    (o_fill_count),
        .o_overflow_flag (o_overflow_flag),
        .o_rts_ready     (o_rts_ready),
        .o_scan_stage    (o_scan_stage),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    h4rx_scan_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_func          (i_func),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_read_byte     (o_read_byte),
        .i_read_valid    (o_read_valid),
        .i_fill_count    (o_fill_count),
        .i_overflow_flag (o_overflow_flag),
        .i_rts_ready     (o_rts_ready),
        .i_scan_stage    (o_scan_stage),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_results       (results)
    );

    // Abort a hung run
    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall, or a long hold-off when asked
    initial begin : result_side
        int hold_left;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
            end else begin
                i_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
            end
        end
    end

    // Offer one transaction and hold it until it is taken
    task automatic push_op(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= f;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        op_cnt[f]++;
        sent_total++;
    endtask

    // Stop sending, then wait out every result and the pipeline
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    // Write the full register set; also poke the unused index
    task automatic program_regs(input logic [7:0] ind, input logic [7:0] evt,
                                input logic [7:0] val, input logic [7:0] margin,
                                input logic [7:0] man_rts, input logic [7:0] scan_en);
        write_reg(CFG_UNUSED, 8'($urandom));
        write_reg(CFG_EVT_IND, ind);
        write_reg(CFG_HW_EVT, evt);
        write_reg(CFG_HW_VAL, val);
        write_reg(CFG_MARGIN, margin);
        write_reg(CFG_MAN_RTS, man_rts);
        write_reg(CFG_SCAN_ON, scan_en);
        i_cfg_valid <= 1'b0;
        cur_ind = ind;
        cur_evt = evt;
        cur_val = val;
    endtask

    // Hardware-error event packet with occasional corruption
    task automatic send_packet();
        logic [BYTE_W-1:0] len;
        len = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255, 1));
        push_op(FUNC_RX, ($urandom_range(99) < 90) ? cur_ind : 8'($urandom));
        push_op(FUNC_RX, ($urandom_range(99) < 90) ? cur_evt : 8'($urandom));
        push_op(FUNC_RX, len);
        push_op(FUNC_RX, ($urandom_range(99) < 75) ? cur_val : 8'($urandom));
    endtask

    task automatic fill_fifo(input int n);
        repeat (n) push_op(FUNC_RX, 8'($urandom));
    endtask

    task automatic send_noise_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            push_op(FUNC_RX, 8'($urandom));
        else if (pick < 60)
            push_op(FUNC_POP, 8'($urandom));
        else if (pick < 75)
            push_op(FUNC_PEEK, 8'($urandom));
        else if (pick < 79)
            push_op(FUNC_FLUSH, 8'($urandom));
        else if (pick < 86)
            push_op(FUNC_CLR_OVF, 8'($urandom));
        else if (pick < 91)
            push_op(FUNC_STOP_SCAN, 8'($urandom));
        else if (pick < 98)
            push_op(FUNC_RESTART_SCAN, 8'($urandom));
        else
            push_op(FUNC_NOP, 8'($urandom));
    endtask

    // Mix of packets, fill and drain bursts, and single operations
    task automatic run_traffic(input int budget);
        int stop_at;
        int pick;
        stop_at = sent_total + budget;
        while (sent_total < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_packet();
            else if (pick < 48)
                fill_fifo($urandom_range(200, 10));
            else if (pick < 58)
                repeat ($urandom_range(200, 10))
                    push_op(($urandom_range(99) < 80) ? FUNC_POP : FUNC_PEEK, 8'($urandom));
            else
                repeat ($urandom_range(8, 1)) send_noise_op();
        end
    endtask

    initial begin : stimulus
        int ph;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pct = 34;
        recv_pct = 59;

        // Directed: empty reads, unused code, extreme bytes, a full error sequence
        push_op(FUNC_PEEK, 8'h00);
        push_op(FUNC_POP, 8'hFF);
        push_op(FUNC_NOP, 8'h5A);
        push_op(FUNC_RX, 8'h00);
        push_op(FUNC_RX, 8'hFF);
        push_op(FUNC_PEEK, 8'h00);
        push_op(FUNC_POP, 8'h00);
        push_op(FUNC_RX, RST_EVT_IND);
        push_op(FUNC_RX, RST_HW_EVT);
        push_op(FUNC_RX, 8'h00);
        push_op(FUNC_RX, RST_EVT_IND);
        push_op(FUNC_RX, RST_HW_EVT);
        push_op(FUNC_RX, 8'h01);
        push_op(FUNC_RX, RST_HW_VAL);
        push_op(FUNC_RX, RST_EVT_IND);
        push_op(FUNC_STOP_SCAN, 8'h00);
        push_op(FUNC_RX, RST_EVT_IND);
        push_op(FUNC_RESTART_SCAN, 8'h00);
        push_op(FUNC_CLR_OVF, 8'h00);
        push_op(FUNC_POP, 8'h00);
        push_op(FUNC_FLUSH, 8'h00);
        push_op(FUNC_POP, 8'h00);

        // Back-pressure: hold off results while offering back to back
        hold_req = 1'b1;
        send_pct = 0;
        repeat (30) send_noise_op();
        send_pct = 34;

        for (ph = 0; ph < 5; ph++) begin
            if (ph < 2) begin
                send_pct = 34;
                recv_pct = 59;
            end else if (ph < 4) begin
                send_pct = 59;
                recv_pct = 34;
            end else begin
                send_pct = 0;
                recv_pct = 0;
            end
            wait_drained();
            case (ph)
                0: program_regs(RST_EVT_IND, RST_HW_EVT, RST_HW_VAL, 8'd0, 8'h01, 8'h01);
                1: program_regs(8'h00, 8'hFF, 8'h00, 8'd255, 8'h01, 8'h01);
                2: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'd128,
                                8'hFE, 8'h01);
                3: program_regs(8'hFF, 8'h00, 8'hFF, 8'd1, 8'h01, 8'h00);
                default: program_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom_range(128)), 8'h01, 8'hFF);
            endcase
            // push past full so bytes get dropped
            if (ph == 1 || ph == 3)
                fill_fifo(FIFO_DEPTH + 3);
            run_traffic(PHASE_ITEMS);
        end

        wait_drained();
        $display("Run covered %0d transactions: %0d receives, %0d pops, %0d peeks, %0d other",
                 sent_total, op_cnt[FUNC_RX], op_cnt[FUNC_POP], op_cnt[FUNC_PEEK],
                 sent_total - op_cnt[FUNC_RX] - op_cnt[FUNC_POP] - op_cnt[FUNC_PEEK]);
        $display("%0d results checked over six register settings and three idle patterns",
                 results);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
